[rtl/pks_pkg.sv]
// ----------------------------------------------------------------------------
// pks_pkg
// Shared types and constants for the pixel to reciprocal-space converter.
// ----------------------------------------------------------------------------
package pks_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned PosW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned WideW    = 64;
  localparam int unsigned RemW     = 36;
  localparam int unsigned DivSteps  = 64;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned StepCntW  = 6;

  // Register reset values.
  localparam logic [DataW-1:0] PixelSizeRst  = 32'd472446;
  localparam logic [DataW-1:0] CameraLenRst  = 32'd0;
  localparam logic [DataW-1:0] WavelengthRst = 32'd268435456;
  localparam logic [DataW-1:0] UpperDRst     = 32'hFFFF_FFFF;
  localparam logic [DataW-1:0] LowerDRst     = 32'd0;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_PIXEL_SIZE    = 3'd0,
    REG_CAMERA_LENGTH = 3'd1,
    REG_WAVELENGTH    = 3'd2,
    REG_LIMIT_ENABLE  = 3'd3,
    REG_WINDOW_UPPER  = 3'd4,
    REG_WINDOW_LOWER  = 3'd5
  } cfg_reg_e;

  // Operations of the shared divide / square-root unit.
  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } arith_op_e;

  typedef struct packed {
    logic             start;
    arith_op_e        op;
    logic [WideW-1:0] opa;
    logic [DataW-1:0] opb;
  } arith_cmd_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [WideW-1:0] value;
  } arith_rsp_t;

endpackage

[rtl/pks_divsqrt.sv]
// ----------------------------------------------------------------------------
// pks_divsqrt
// Shared bit-serial unit: unsigned 64 / 32 restoring divide (one quotient
// bit a cycle) and 64-bit integer square root (one root bit a cycle).
// ----------------------------------------------------------------------------
module pks_divsqrt import pks_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  arith_cmd_t cmd_i,
  output arith_rsp_t rsp_o
);

  logic                busy_q;
  logic                done_q;
  arith_op_e           op_q;
  logic [StepCntW-1:0] cnt_q;
  logic [WideW-1:0]    acc_q;
  logic [RemW-1:0]     rem_q;
  logic [DataW-1:0]    root_q;
  logic [DataW-1:0]    div_q;

  logic [RemW-1:0]     rem_shift;
  logic [RemW-1:0]     trial;
  logic [RemW:0]       diff;
  logic                fits;
  logic                last;

  // One subtractor serves both operations.
  always_comb begin
    if (op_q == OP_DIV) begin
      rem_shift = {rem_q[RemW-2:0], acc_q[WideW-1]};
      trial     = {{(RemW-DataW){1'b0}}, div_q};
      last      = (cnt_q == StepCntW'(DivSteps - 1));
    end else begin
      rem_shift = {rem_q[RemW-3:0], acc_q[WideW-1:WideW-2]};
      trial     = {{(RemW-DataW-2){1'b0}}, root_q, 2'b01};
      last      = (cnt_q == StepCntW'(SqrtSteps - 1));
    end
    diff = {1'b0, rem_shift} - {1'b0, trial};
    fits = ~diff[RemW];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_DIV;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start && !busy_q) begin
        busy_q <= 1'b1;
        op_q   <= cmd_i.op;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start && !busy_q) begin
      acc_q  <= cmd_i.opa;
      div_q  <= cmd_i.opb;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[RemW-1:0] : rem_shift;
      if (op_q == OP_DIV) begin
        acc_q <= {acc_q[WideW-2:0], fits};
      end else begin
        acc_q  <= {acc_q[WideW-3:0], 2'b00};
        root_q <= {root_q[DataW-2:0], fits};
      end
    end
  end

  assign rsp_o.busy  = busy_q;
  assign rsp_o.done  = done_q;
  assign rsp_o.value = (op_q == OP_DIV) ? acc_q : {{(WideW-DataW){1'b0}}, root_q};

endmodule

[rtl/pixel_kspace_resolution.sv]
// ----------------------------------------------------------------------------
// pixel_kspace_resolution
// Converts detector pixel positions to reciprocal-space vectors and
// d-spacing, with a resolution window flag and running d-spacing extremes.
// ----------------------------------------------------------------------------
// Usage:
// Configuration writes go through the cfg channel (index, data); it is
// always ready and should be used only while no pixel is in flight.
// Each pixel transaction on the input channel carries a position and a
// first-pixel flag and yields exactly one result transaction.
// Each pixel runs seven divides and two square roots on the shared
// bit-serial unit, one after another; the multiplies and sums of squares
// run in the sequencer. A position at the origin skips the three
// unit-vector divides and the d-spacing divide.
// The block takes one pixel at a time: the next pixel is accepted at the
// earliest in the cycle after the result is loaded.
// The result sits in an output register, so the next pixel is accepted
// while a result waits; if the receiver stalls, the finished pixel holds
// in the final step until the output register frees.
// Reset restores the register defaults, clears the running largest
// d-spacing to zero and sets the running smallest to all ones.
// ----------------------------------------------------------------------------
module pixel_kspace_resolution import pks_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [DataW-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [PosW-1:0] pos_x_i,
  input  logic signed [PosW-1:0] pos_y_i,
  input  logic signed [PosW-1:0] pos_z_i,
  input  logic                first_pixel_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [DataW-1:0] k_x_o,
  output logic signed [DataW-1:0] k_y_o,
  output logic signed [DataW-1:0] k_z_o,
  output logic [DataW-1:0]    k_mag_o,
  output logic [DataW-1:0]    d_spacing_o,
  output logic                mask_written_o,
  output logic                in_window_o,
  output logic [DataW-1:0]    largest_d_o,
  output logic [DataW-1:0]    smallest_d_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_ADD_Z,
    ST_TRUNC_Z,
    ST_SQ,
    ST_ACC,
    ST_ROOT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    DP_UNIT,
    DP_K,
    DP_D
  } div_phase_e;

  // Configuration registers.
  logic [DataW-1:0] pixel_size_q, camera_len_q, wavelength_q, upper_q, lower_q;
  logic             limit_en_q;

  // Sequencer state.
  state_e     state_q;
  div_phase_e dphase_q;
  logic       kphase_q;
  logic [1:0] idx_q;
  logic       out_valid_q;
  logic [DataW-1:0] max_d_q, min_d_q;

  // Working registers.
  logic signed [PosW-1:0]  px_q, py_q, pz_q;
  logic                    first_q;
  logic signed [65:0]      mul_q;
  logic [WideW-1:0]        acc_q;
  logic signed [32:0]      coord_q [3];
  logic signed [DataW-1:0] u_q [3];
  logic signed [DataW-1:0] k_q [3];
  logic [30:0]             r_q;
  logic [DataW-1:0]        kr_q;
  logic [DataW-1:0]        dq_q;

  // Output registers.
  logic signed [DataW-1:0] kx_o_q, ky_o_q, kz_o_q;
  logic [DataW-1:0]        kmag_o_q, d_o_q;
  logic                    mask_o_q, win_o_q;

  arith_cmd_t arith_cmd;
  arith_rsp_t arith_rsp;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [WideW-1:0]   acc_sum;
  logic [DataW-1:0]   lam_eff;
  logic [32:0]        coord_mag;
  logic [DataW-1:0]   u_mag;
  logic               out_free;
  logic [DataW-1:0]   max_base, min_base, max_new, min_new;
  logic [DataW-1:0]   q_lo;
  logic               q_hi;
  logic [DataW-1:0]   u_res, k_res;

  // Truncating divide by 2^18 of a signed product.
  function automatic logic signed [32:0] trunc18(input logic signed [65:0] v);
    logic signed [65:0] t;
    t = v + (v[65] ? 66'sd262143 : 66'sd0);
    return t[50:18];
  endfunction

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL_X: begin
        mul_a = {{17{px_q[PosW-1]}}, px_q};
        mul_b = {1'b0, pixel_size_q};
      end
      ST_MUL_Y: begin
        mul_a = {{17{py_q[PosW-1]}}, py_q};
        mul_b = {1'b0, pixel_size_q};
      end
      ST_MUL_Z: begin
        mul_a = {{17{pz_q[PosW-1]}}, pz_q};
        mul_b = {1'b0, pixel_size_q};
      end
      ST_SQ: begin
        if (kphase_q) begin
          mul_a = {k_q[idx_q][DataW-1], k_q[idx_q]};
        end else begin
          mul_a = coord_q[idx_q];
        end
        mul_b = mul_a;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Running sum of squares and the divider operands.
  always_comb begin
    acc_sum   = ((idx_q == 2'd0) ? '0 : acc_q) + mul_q[WideW-1:0];
    lam_eff   = (wavelength_q == '0) ? 32'd1 : wavelength_q;
    coord_mag = coord_q[idx_q][32] ? 33'(-coord_q[idx_q]) : 33'(coord_q[idx_q]);
    u_mag     = u_q[idx_q][DataW-1] ? (32'd0 - u_q[idx_q]) : u_q[idx_q];

    arith_cmd.start = 1'b0;
    arith_cmd.op    = OP_DIV;
    arith_cmd.opa   = '0;
    arith_cmd.opb   = '0;
    if (state_q == ST_ACC && idx_q == 2'd2) begin
      arith_cmd.start = 1'b1;
      arith_cmd.op    = OP_SQRT;
      arith_cmd.opa   = acc_sum;
    end else if (state_q == ST_DIV_GO) begin
      arith_cmd.start = 1'b1;
      case (dphase_q)
        DP_UNIT: begin
          arith_cmd.opa = {1'b0, coord_mag, 30'd0};
          arith_cmd.opb = {1'b0, r_q};
        end
        DP_K: begin
          arith_cmd.opa = {6'd0, u_mag, 26'd0};
          arith_cmd.opb = lam_eff;
        end
        default: begin
          arith_cmd.opa = 64'd1 << 44;
          arith_cmd.opb = kr_q;
        end
      endcase
    end
  end

  // Sign and saturation of a finished quotient.
  always_comb begin
    q_lo = arith_rsp.value[DataW-1:0];
    q_hi = |arith_rsp.value[WideW-1:DataW];
    u_res = coord_q[idx_q][32] ? (32'd0 - q_lo) : q_lo;
    if (idx_q == 2'd2) begin
      u_res = u_res - 32'h4000_0000;
    end
    if (u_q[idx_q][DataW-1]) begin
      k_res = (q_hi || q_lo > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - q_lo);
    end else begin
      k_res = (q_hi || q_lo[DataW-1]) ? 32'h7FFF_FFFF : q_lo;
    end
  end

  // Running extremes, restarted by the first-pixel flag.
  always_comb begin
    out_free = !out_valid_q || out_ready_i;
    max_base = first_q ? '0 : max_d_q;
    min_base = first_q ? '1 : min_d_q;
    max_new  = (dq_q > max_base) ? dq_q : max_base;
    min_new  = (dq_q < min_base) ? dq_q : min_base;
  end

  pks_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (arith_cmd),
    .rsp_o  (arith_rsp)
  );

  // Sequencer, configuration registers and result handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      dphase_q     <= DP_UNIT;
      kphase_q     <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      max_d_q      <= '0;
      min_d_q      <= '1;
      pixel_size_q <= PixelSizeRst;
      camera_len_q <= CameraLenRst;
      wavelength_q <= WavelengthRst;
      limit_en_q   <= 1'b0;
      upper_q      <= UpperDRst;
      lower_q      <= LowerDRst;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_PIXEL_SIZE:    pixel_size_q <= cfg_data_i;
          REG_CAMERA_LENGTH: camera_len_q <= cfg_data_i;
          REG_WAVELENGTH:    wavelength_q <= cfg_data_i;
          REG_LIMIT_ENABLE:  limit_en_q   <= cfg_data_i[0];
          REG_WINDOW_UPPER:  upper_q      <= cfg_data_i;
          REG_WINDOW_LOWER:  lower_q      <= cfg_data_i;
          default: ;
        endcase
      end

      // A new result loads the output register; otherwise it empties when taken.
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_MUL_X;
          end
        end
        ST_MUL_X:   state_q <= ST_MUL_Y;
        ST_MUL_Y:   state_q <= ST_MUL_Z;
        ST_MUL_Z:   state_q <= ST_ADD_Z;
        ST_ADD_Z:   state_q <= ST_TRUNC_Z;
        ST_TRUNC_Z: begin
          idx_q    <= '0;
          kphase_q <= 1'b0;
          state_q  <= ST_SQ;
        end
        ST_SQ:      state_q <= ST_ACC;
        ST_ACC: begin
          if (idx_q == 2'd2) begin
            state_q <= ST_ROOT;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_SQ;
          end
        end
        ST_ROOT: begin
          if (arith_rsp.done) begin
            idx_q <= '0;
            if (!kphase_q) begin
              dphase_q <= (arith_rsp.value == '0) ? DP_K : DP_UNIT;
              state_q  <= ST_DIV_GO;
            end else if (arith_rsp.value == '0) begin
              state_q <= ST_DONE;
            end else begin
              dphase_q <= DP_D;
              state_q  <= ST_DIV_GO;
            end
          end
        end
        ST_DIV_GO:  state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (arith_rsp.done) begin
            case (dphase_q)
              DP_UNIT: begin
                state_q <= ST_DIV_GO;
                if (idx_q == 2'd2) begin
                  idx_q    <= '0;
                  dphase_q <= DP_K;
                end else begin
                  idx_q <= idx_q + 1'b1;
                end
              end
              DP_K: begin
                if (idx_q == 2'd2) begin
                  idx_q    <= '0;
                  kphase_q <= 1'b1;
                  state_q  <= ST_SQ;
                end else begin
                  idx_q   <= idx_q + 1'b1;
                  state_q <= ST_DIV_GO;
                end
              end
              default: state_q <= ST_DONE;
            endcase
          end
        end
        ST_DONE: begin
          if (out_free) begin
            max_d_q     <= max_new;
            min_d_q     <= min_new;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath and result payload registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        px_q    <= pos_x_i;
        py_q    <= pos_y_i;
        pz_q    <= pos_z_i;
        first_q <= first_pixel_i;
      end
      ST_MUL_X: mul_q <= mul_p;
      ST_MUL_Y: begin
        coord_q[0] <= trunc18(mul_q);
        mul_q      <= mul_p;
      end
      ST_MUL_Z: begin
        coord_q[1] <= trunc18(mul_q);
        mul_q      <= mul_p;
      end
      ST_ADD_Z:   mul_q <= mul_q + $signed({22'd0, camera_len_q, 12'd0});
      ST_TRUNC_Z: coord_q[2] <= trunc18(mul_q);
      ST_SQ:      mul_q <= mul_p;
      ST_ACC:     acc_q <= acc_sum;
      ST_ROOT: begin
        if (arith_rsp.done) begin
          if (!kphase_q) begin
            r_q <= arith_rsp.value[30:0];
            if (arith_rsp.value == '0) begin
              u_q[0] <= '0;
              u_q[1] <= '0;
              u_q[2] <= '0;
            end
          end else begin
            kr_q <= arith_rsp.value[DataW-1:0];
            dq_q <= '1;
          end
        end
      end
      ST_DIV_WAIT: begin
        if (arith_rsp.done) begin
          case (dphase_q)
            DP_UNIT: u_q[idx_q] <= u_res;
            DP_K:    k_q[idx_q] <= k_res;
            default: dq_q <= q_hi ? '1 : q_lo;
          endcase
        end
      end
      ST_DONE: begin
        if (out_free) begin
          kx_o_q   <= k_q[0];
          ky_o_q   <= k_q[1];
          kz_o_q   <= k_q[2];
          kmag_o_q <= kr_q;
          d_o_q    <= dq_q;
          mask_o_q <= limit_en_q;
          win_o_q  <= limit_en_q && (dq_q < upper_q) && (dq_q > lower_q);
        end
      end
      default: ;
    endcase
  end

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign k_x_o          = kx_o_q;
  assign k_y_o          = ky_o_q;
  assign k_z_o          = kz_o_q;
  assign k_mag_o        = kmag_o_q;
  assign d_spacing_o    = d_o_q;
  assign mask_written_o = mask_o_q;
  assign in_window_o    = win_o_q;
  assign largest_d_o    = max_d_q;
  assign smallest_d_o   = min_d_q;

  // A zero magnitude always gives the saturated d-spacing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (k_mag_o == '0) |-> (d_spacing_o == '1))
    else $error("d-spacing not saturated for zero magnitude");

  // The running extremes bracket the pixel just delivered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (smallest_d_o <= d_spacing_o) && (largest_d_o >= d_spacing_o))
    else $error("running extremes do not bracket d-spacing");

  // The window flag is only raised when it is written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !mask_written_o |-> !in_window_o)
    else $error("window flag set while limiting is off");

  // The shared unit finishes only while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_rsp.done |-> (state_q == ST_ROOT) || (state_q == ST_DIV_WAIT))
    else $error("shared unit finished while sequencer was not waiting");

endmodule
